>>> hw/rtl/trapezoidal_servo_profile_defines.svh
// assertion macros for the servo profile block
`ifndef TRAPEZOIDAL_SERVO_PROFILE_DEFINES_SVH
`define TRAPEZOIDAL_SERVO_PROFILE_DEFINES_SVH

// same-cycle implication
`define TSP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/tsp_pkg.sv
// ----------------------------------------------------------------------------
// tsp_pkg
// types and constants for the trapezoidal servo profile generator
// ----------------------------------------------------------------------------
package tsp_pkg;

	localparam int ANGLE_FRAC_BITS = 8;
	localparam int ANGLE_W = 16;
	localparam int SPEED_W = 24;
	localparam int RATE_W = 20;
	localparam int VMAX_W = 17;
	localparam int DT_W = 10;
	localparam int KIND_W = 2;
	localparam int CFG_IDX_W = 2;

	// shared multiplier operand widths
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 33;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// shared restoring divider, divides by the tick length only
	localparam int DIV_N_W = 36;
	localparam int DIV_D_W = 11;
	localparam int DIV_CNT_W = 6;

	// 1000 = 8 * 125 and 2000 = 16 * 125; x / 125 = (x * ceil(2^39 / 125)) >> 39
	// holds exactly for every x below 2^32
	localparam int MS_SHIFT = 3;
	localparam int TWO_MS_SHIFT = 4;
	localparam int RECIP_SHIFT = 39;
	localparam logic [MUL_B_W-1:0] RECIP_125 = 33'd4398046512;

	localparam logic [ANGLE_W-1:0] RESET_ANGLE = ANGLE_W'(90 << ANGLE_FRAC_BITS);
	localparam logic [RATE_W-1:0] RESET_RATE = RATE_W'(2560);
	localparam logic [VMAX_W-1:0] RESET_VMAX = VMAX_W'(7680);
	localparam logic [SPEED_W-1:0] SPEED_SAT = '1;
	localparam logic [DIV_D_W-1:0] MS_PER_S = DIV_D_W'(1000);
	localparam logic [31:0] ONE_DEG = 32'(1) << ANGLE_FRAC_BITS;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_ACCEL = 2'd1,
		MODE_CRUISE = 2'd2,
		MODE_DECEL = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_TICK = 2'd0,
		KIND_MOVE = 2'd1,
		KIND_STOP = 2'd2,
		KIND_SET = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_ACCEL = 2'd0,
		REG_DECEL = 2'd1,
		REG_VMAX = 2'd2
	} reg_idx_t;

	typedef enum logic [10:0] {
		S_IDLE = 11'b000_0000_0001,
		S_SQ = 11'b000_0000_0010,
		S_BRK = 11'b000_0000_0100,
		S_RMUL = 11'b000_0000_1000,
		S_RDIV = 11'b000_0001_0000,
		S_SMUL = 11'b000_0010_0000,
		S_SDIV = 11'b000_0100_0000,
		S_POS = 11'b000_1000_0000,
		S_VMUL = 11'b001_0000_0000,
		S_VDIV = 11'b010_0000_0000,
		S_OUT = 11'b100_0000_0000
	} state_t;

	// near the goal: within 0.1 degree
	function automatic logic near_goal(input logic [ANGLE_W-1:0] a,
			input logic [ANGLE_W-1:0] b);
		logic [ANGLE_W-1:0] d;
		logic [ANGLE_W+3:0] d10;
		begin
			d = (a > b) ? a - b : b - a;
			d10 = (ANGLE_W+4)'(d) * (ANGLE_W+4)'(10);
			near_goal = 32'(d10) < ONE_DEG;
		end
	endfunction

endpackage

>>> hw/rtl/trapezoidal_servo_profile.sv
// a moving tick item runs the sequencer from acceptance to the result register, and
// skips the step multiply and divide while cruising; other items and idle or
// zero-length ticks go straight to the result state; a new item is taken only
// once the sequencer is idle again, and the speed is set by the 36-step divide by dt
// reset: position and goal 90 degrees, speed zero, idle, default rates
// ----------------------------------------------------------------------------
// trapezoidal_servo_profile
// trapezoidal velocity profile for a servo angle, one shared multiplier and
// one shared bit-serial divider under a one-hot sequencer
// ----------------------------------------------------------------------------
`include "trapezoidal_servo_profile_defines.svh"

module trapezoidal_servo_profile (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [tsp_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [tsp_pkg::RATE_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [tsp_pkg::KIND_W-1:0] kind,
	input logic [tsp_pkg::ANGLE_W-1:0] target_angle,
	input logic [tsp_pkg::DT_W-1:0] elapsed_ms,
	output logic out_valid,
	input logic out_stall,
	output logic [tsp_pkg::ANGLE_W-1:0] servo_angle,
	output logic servo_write,
	output logic [1:0] motion_mode,
	output logic [tsp_pkg::SPEED_W-1:0] speed,
	output logic at_target
);
	import tsp_pkg::*;

	state_t state_q;
	mode_t mode_q;
	logic [RATE_W-1:0] accel_q, decel_q;
	logic [VMAX_W-1:0] vmax_q;
	logic [ANGLE_W-1:0] pos_q, goal_q, change_q;
	logic [SPEED_W-1:0] vel_q, nv_q;
	logic [DT_W-1:0] dt_q;
	logic [2*SPEED_W-1:0] vsq_q;
	logic [DIV_N_W-1:0] step_q;
	logic wrote_q;

	logic [DIV_N_W-1:0] quot_q;
	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	logic out_valid_q;
	logic [ANGLE_W-1:0] angle_q;
	logic write_q;
	logic [1:0] omode_q;
	logic [SPEED_W-1:0] speed_q;
	logic at_target_q;

	logic accept;
	logic [ANGLE_W-1:0] goal_gap;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] prod;
	logic [DIV_N_W-1:0] rquot;
	logic must_brake;
	logic [DIV_D_W-1:0] divisor;
	logic [DIV_D_W:0] rem_sh;
	logic div_ge;
	logic [DIV_D_W-1:0] rem_nx;
	logic [DIV_N_W-1:0] quot_nx;
	logic div_last;
	logic [DIV_N_W:0] acc_sum;
	logic [ANGLE_W-1:0] chg;
	logic [SPEED_W-1:0] vel_new;
	logic [SPEED_W+6:0] vel100;

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign accept = in_valid && !in_stall;

	assign goal_gap = (goal_q > pos_q) ? goal_q - pos_q : pos_q - goal_q;

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SQ: begin
				mul_a = MUL_A_W'(vel_q);
				mul_b = MUL_B_W'(vel_q);
			end
			S_BRK: begin
				mul_a = MUL_A_W'(decel_q);
				mul_b = MUL_B_W'(goal_gap);
			end
			S_RMUL: begin
				case (mode_q)
					MODE_ACCEL: mul_a = MUL_A_W'(accel_q);
					MODE_CRUISE: mul_a = MUL_A_W'(vmax_q);
					default: mul_a = MUL_A_W'(decel_q);
				endcase
				mul_b = MUL_B_W'(dt_q);
			end
			// divide by 1000 through the reciprocal of 125
			S_RDIV: begin
				mul_a = MUL_A_W'(quot_q >> MS_SHIFT);
				mul_b = RECIP_125;
			end
			S_SMUL: begin
				mul_a = MUL_A_W'(vel_q) + MUL_A_W'(nv_q);
				mul_b = MUL_B_W'(dt_q);
			end
			// divide by 2000 through the reciprocal of 125
			S_SDIV: begin
				mul_a = MUL_A_W'(quot_q >> TWO_MS_SHIFT);
				mul_b = RECIP_125;
			end
			S_VMUL: begin
				mul_a = MUL_A_W'(change_q);
				mul_b = MUL_B_W'(MS_PER_S);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
	assign rquot = DIV_N_W'(prod[MUL_P_W-1:RECIP_SHIFT]);
	assign must_brake = (2*SPEED_W)'({prod[RATE_W+ANGLE_W-1:0], 1'b0}) <= vsq_q;

	assign divisor = DIV_D_W'(dt_q);

	// one quotient bit per cycle
	assign rem_sh = {rem_q, quot_q[DIV_N_W-1]};
	assign div_ge = rem_sh >= (DIV_D_W+1)'(divisor);
	assign rem_nx = div_ge ? DIV_D_W'(rem_sh - (DIV_D_W+1)'(divisor)) : rem_sh[DIV_D_W-1:0];
	assign quot_nx = {quot_q[DIV_N_W-2:0], div_ge};
	assign div_last = cnt_q == DIV_CNT_W'(DIV_N_W - 1);

	assign acc_sum = (DIV_N_W+1)'(vel_q) + (DIV_N_W+1)'(rquot);
	assign chg = (step_q >= DIV_N_W'(goal_gap)) ? goal_gap : step_q[ANGLE_W-1:0];
	assign vel_new = (quot_nx > DIV_N_W'(SPEED_SAT)) ? SPEED_SAT : quot_nx[SPEED_W-1:0];
	assign vel100 = (SPEED_W+7)'(vel_new) * (SPEED_W+7)'(100);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_q <= RESET_RATE;
			decel_q <= RESET_RATE;
			vmax_q <= RESET_VMAX;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ACCEL: accel_q <= cfg_data;
				REG_DECEL: decel_q <= cfg_data;
				REG_VMAX: vmax_q <= cfg_data[VMAX_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= MODE_IDLE;
			pos_q <= RESET_ANGLE;
			goal_q <= RESET_ANGLE;
			vel_q <= '0;
			wrote_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						wrote_q <= 1'b0;
						state_q <= S_OUT;
						case (kind_t'(kind))
							KIND_TICK: begin
								if (mode_q != MODE_IDLE && elapsed_ms != '0) begin
									wrote_q <= 1'b1;
									state_q <= S_SQ;
								end
							end
							KIND_MOVE: begin
								goal_q <= target_angle;
								mode_q <= MODE_ACCEL;
								vel_q <= '0;
							end
							KIND_STOP: begin
								mode_q <= MODE_DECEL;
								goal_q <= pos_q;
							end
							default: begin
								pos_q <= target_angle;
								goal_q <= target_angle;
								vel_q <= '0;
								mode_q <= MODE_IDLE;
							end
						endcase
					end
				end
				S_SQ: state_q <= S_BRK;
				S_BRK: begin
					// phase choice from stopping distance
					if (mode_q == MODE_ACCEL) begin
						if (vel_q >= SPEED_W'(vmax_q))
							mode_q <= MODE_CRUISE;
						else if (must_brake)
							mode_q <= MODE_DECEL;
					end else if (mode_q == MODE_CRUISE && must_brake) begin
						mode_q <= MODE_DECEL;
					end
					state_q <= S_RMUL;
				end
				S_RMUL: state_q <= S_RDIV;
				S_RDIV: begin
					case (mode_q)
						MODE_CRUISE: state_q <= S_POS;
						default: state_q <= S_SMUL;
					endcase
				end
				S_SMUL: state_q <= S_SDIV;
				S_SDIV: state_q <= S_POS;
				S_POS: begin
					pos_q <= (goal_q > pos_q) ? pos_q + chg : pos_q - chg;
					state_q <= S_VMUL;
				end
				S_VMUL: begin
					cnt_q <= '0;
					state_q <= S_VDIV;
				end
				S_VDIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (div_last) begin
						if (near_goal(pos_q, goal_q) && 32'(vel100) < ONE_DEG) begin
							mode_q <= MODE_IDLE;
							vel_q <= '0;
						end else begin
							vel_q <= vel_new;
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		if (accept)
			dt_q <= elapsed_ms;
		case (state_q)
			S_SQ: vsq_q <= prod[2*SPEED_W-1:0];
			S_RMUL, S_SMUL, S_VMUL: begin
				quot_q <= prod[DIV_N_W-1:0];
				rem_q <= '0;
			end
			S_RDIV: begin
				case (mode_q)
					MODE_CRUISE: step_q <= rquot;
					MODE_ACCEL: nv_q <= (acc_sum > (DIV_N_W+1)'(vmax_q)) ?
							SPEED_W'(vmax_q) : acc_sum[SPEED_W-1:0];
					default: nv_q <= (DIV_N_W'(vel_q) > rquot) ?
							vel_q - rquot[SPEED_W-1:0] : '0;
				endcase
			end
			S_SDIV: step_q <= rquot;
			S_VDIV: begin
				quot_q <= quot_nx;
				rem_q <= rem_nx;
			end
			S_POS: change_q <= chg;
			default: ;
		endcase
		if (state_q == S_OUT) begin
			angle_q <= pos_q;
			write_q <= wrote_q;
			omode_q <= mode_q;
			speed_q <= vel_q;
			at_target_q <= (mode_q == MODE_IDLE) && near_goal(pos_q, goal_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == S_OUT)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;
	assign servo_angle = angle_q;
	assign servo_write = write_q;
	assign motion_mode = omode_q;
	assign speed = speed_q;
	assign at_target = at_target_q;

	`TSP_ASSERT_NOW(a_accept_idle, accept, state_q == S_IDLE, "request taken while busy")
	`TSP_ASSERT_NOW(a_idle_still, mode_q == MODE_IDLE, vel_q == '0, "idle with nonzero speed")
	`TSP_ASSERT_NOW(a_div_count, state_q == S_VDIV, cnt_q < DIV_CNT_W'(DIV_N_W), "divider count overrun")
	`TSP_ASSERT_NOW(a_out_free, state_q == S_OUT, !out_valid_q, "result register still occupied")
	`TSP_ASSERT_NEXT(a_pos_to_vmul, state_q == S_POS, state_q == S_VMUL, "position update not followed by speed")

endmodule

>>> tb/tsp_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tsp_result_checker
// follows the register writes and the accepted requests, keeps its own profile
// state, predicts each result and compares it field by field with the block
// ----------------------------------------------------------------------------
module tsp_result_checker (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [tsp_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [tsp_pkg::RATE_W-1:0] cfg_data,
	input logic in_valid,
	input logic in_stall,
	input logic [tsp_pkg::KIND_W-1:0] kind,
	input logic [tsp_pkg::ANGLE_W-1:0] target_angle,
	input logic [tsp_pkg::DT_W-1:0] elapsed_ms,
	input logic out_valid,
	input logic out_stall,
	input logic [tsp_pkg::ANGLE_W-1:0] servo_angle,
	input logic servo_write,
	input logic [1:0] motion_mode,
	input logic [tsp_pkg::SPEED_W-1:0] speed,
	input logic at_target,
	output int fail_count,
	output int pending
);
	import tsp_pkg::*;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle;
		logic wr;
		logic [1:0] mode;
		logic [SPEED_W-1:0] spd;
		logic at;
	} servo_result_t;

	servo_result_t expected_results[$];
	longint unsigned acc_rate, dec_rate, vmax;
	longint unsigned pos, goal_pos, vel;
	mode_t cur_mode;

	assign pending = expected_results.size();

	function automatic longint unsigned goal_dist();
		return (goal_pos > pos) ? goal_pos - pos : pos - goal_pos;
	endfunction

	function automatic bit is_near();
		return goal_dist() * 10 < (longint'(1) << ANGLE_FRAC_BITS);
	endfunction

	task automatic advance_tick(input longint unsigned dt);
		longint unsigned d, nv, stp, chg, dec;
		longint np;
		bit brake;
		d = goal_dist();
		brake = 2 * dec_rate * d <= vel * vel;
		if (cur_mode == MODE_ACCEL) begin
			if (vel >= vmax) cur_mode = MODE_CRUISE;
			else if (brake) cur_mode = MODE_DECEL;
		end else if (cur_mode == MODE_CRUISE && brake) begin
			cur_mode = MODE_DECEL;
		end
		if (cur_mode == MODE_ACCEL) begin
			nv = vel + acc_rate * dt / 1000;
			if (nv > vmax) nv = vmax;
			stp = (vel + nv) * dt / 2000;
		end else if (cur_mode == MODE_CRUISE) begin
			stp = vmax * dt / 1000;
		end else begin
			dec = dec_rate * dt / 1000;
			nv = (vel > dec) ? vel - dec : 0;
			stp = (vel + nv) * dt / 2000;
		end
		if (goal_pos > pos) begin
			np = longint'(pos) + longint'(stp);
			if (np > longint'(goal_pos)) np = goal_pos;
		end else begin
			np = longint'(pos) - longint'(stp);
			if (np < longint'(goal_pos)) np = goal_pos;
		end
		chg = (np > longint'(pos)) ? np - pos : pos - np;
		vel = chg * 1000 / dt;
		if (vel > 64'hFFFFFF) vel = 64'hFFFFFF;
		pos = np & 16'hFFFF;
		if (is_near() && vel * 100 < (longint'(1) << ANGLE_FRAC_BITS)) begin
			cur_mode = MODE_IDLE;
			vel = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		servo_result_t r, got;
		bit wr;
		if (!arst_n) begin
			acc_rate = RESET_RATE;
			dec_rate = RESET_RATE;
			vmax = RESET_VMAX;
			pos = RESET_ANGLE;
			goal_pos = RESET_ANGLE;
			vel = 0;
			cur_mode = MODE_IDLE;
			fail_count = 0;
			expected_results.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_ACCEL: acc_rate = cfg_data;
					REG_DECEL: dec_rate = cfg_data;
					REG_VMAX: vmax = cfg_data & 20'h1FFFF;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				wr = 0;
				case (kind_t'(kind))
					KIND_TICK: begin
						if (cur_mode != MODE_IDLE && elapsed_ms != 0) begin
							advance_tick(elapsed_ms);
							wr = 1;
						end
					end
					KIND_MOVE: begin
						goal_pos = target_angle;
						cur_mode = MODE_ACCEL;
						vel = 0;
					end
					KIND_STOP: begin
						cur_mode = MODE_DECEL;
						goal_pos = pos;
					end
					default: begin
						pos = target_angle;
						goal_pos = target_angle;
						vel = 0;
						cur_mode = MODE_IDLE;
					end
				endcase
				r.angle = pos[ANGLE_W-1:0];
				r.wr = wr;
				r.mode = cur_mode;
				r.spd = vel[SPEED_W-1:0];
				r.at = (cur_mode == MODE_IDLE) && is_near();
				expected_results.push_back(r);
			end
			if (out_valid && !out_stall) begin
				got = '{servo_angle, servo_write, motion_mode, speed, at_target};
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, actual %p", $time, got);
					fail_count++;
				end else begin
					r = expected_results.pop_front();
					if (got.angle !== r.angle || got.wr !== r.wr || got.mode !== r.mode ||
							got.spd !== r.spd || got.at !== r.at) begin
						$display("%0t: expected %p actual %p", $time, r, got);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

>>> tb/tb_trapezoidal_servo_profile.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_trapezoidal_servo_profile
// directed and random moves, stops, sets and ticks under several rate
// settings, with random gaps on both sides; a checker predicts every result
// ----------------------------------------------------------------------------
module tb_trapezoidal_servo_profile;
	import tsp_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [RATE_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic [KIND_W-1:0] kind = '0;
	logic [ANGLE_W-1:0] target_angle = '0;
	logic [DT_W-1:0] elapsed_ms = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [ANGLE_W-1:0] servo_angle;
	logic servo_write;
	logic [1:0] motion_mode;
	logic [SPEED_W-1:0] speed;
	logic at_target;
	int fail_count, pending;
	int stall_left = 0;
	longint cycle_count = 0;

	always #6 clk = ~clk;

	trapezoidal_servo_profile u_dut (.*);

	tsp_result_checker u_checker (.*);

	function automatic int gap_len();
		int p = $urandom_range(0, 99);
		if (p < 40) return 0;
		if (p < 92) return $urandom_range(1, 4);
		return $urandom_range(10, 150);
	endfunction

	// receiver stalls in runs of random length
	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1;
			end else begin
				out_stall <= 0;
				if ($urandom_range(0, 1) == 0) stall_left = gap_len();
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 3000000) begin
			$display("trapezoidal_servo_profile: mismatch");
			$finish;
		end
	end

	// valid stays high into the next request when there is no gap
	task automatic send_request(input kind_t k, input int ang, input int dt);
		int g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1;
		kind <= k;
		target_angle <= ANGLE_W'(ang);
		elapsed_ms <= DT_W'(dt);
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic hold_off();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic wait_drained();
		hold_off();
		repeat (150) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input int val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= RATE_W'(val);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic random_angle(output int a);
		int p = $urandom_range(0, 9);
		if (p == 0) a = $urandom_range(0, 65535);
		else if (p == 1) a = $urandom_range(0, 1) ? 0 : 46080;
		else a = $urandom_range(0, 46080);
	endtask

	// a move, then a random number of ticks, maybe a stop midway
	task automatic random_move(inout int sent);
		int ang, n;
		random_angle(ang);
		send_request(KIND_MOVE, ang, $urandom_range(0, 1023));
		sent++;
		n = $urandom_range(3, 30);
		for (int i = 0; i < n; i++) begin
			int dt, p;
			p = $urandom_range(0, 19);
			if (p == 0) dt = 0;
			else if (p == 1) dt = $urandom_range(1, 1023);
			else if (p < 4) dt = $urandom_range(1, 3);
			else dt = $urandom_range(5, 60);
			if ($urandom_range(0, 29) == 0) send_request(KIND_STOP, $urandom, $urandom);
			else send_request(KIND_TICK, $urandom, dt);
			sent++;
		end
	endtask

	int sent;
	int rate_sets[5][3] = '{
		'{2560, 2560, 7680},
		'{1, 1, 1},
		'{1048575, 1048575, 92160},
		'{100000, 3000, 40000},
		'{500, 200000, 2000}
	};

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: every kind, field extremes, stop from idle, zero dt
		send_request(KIND_TICK, 16'hFFFF, 10);
		send_request(KIND_STOP, 0, 0);
		send_request(KIND_TICK, 0, 10);
		send_request(KIND_TICK, 0, 10);
		send_request(KIND_SET, 0, 1023);
		send_request(KIND_MOVE, 46080, 0);
		send_request(KIND_TICK, 0, 0);
		send_request(KIND_TICK, 0, 1023);
		send_request(KIND_TICK, 0, 1);
		send_request(KIND_TICK, 0, 1023);
		send_request(KIND_STOP, 16'hFFFF, 1023);
		send_request(KIND_TICK, 0, 20);
		send_request(KIND_SET, 16'hFFFF, 0);
		send_request(KIND_MOVE, 0, 512);
		send_request(KIND_TICK, 16'hAAAA, 341);
		send_request(KIND_TICK, 16'h5555, 682);
		send_request(KIND_MOVE, 23040, 0);
		send_request(KIND_TICK, 0, 500);
		send_request(KIND_TICK, 0, 500);
		send_request(KIND_TICK, 0, 500);
		sent = 20;
		for (int s = 0; s < 5; s++) begin
			wait_drained();
			write_reg(REG_ACCEL, rate_sets[s][0]);
			write_reg(REG_DECEL, rate_sets[s][1]);
			write_reg(REG_VMAX, rate_sets[s][2]);
			while (sent < 20 + 150 * (s + 1)) begin
				if ($urandom_range(0, 9) == 0) begin
					send_request(KIND_SET, $urandom, $urandom);
					sent++;
				end
				random_move(sent);
				// hold off until everything has come back
				if ($urandom_range(0, 7) == 0) hold_off();
			end
		end
		wait_drained();
		if (fail_count == 0)
			$display("trapezoidal_servo_profile: match");
		else
			$display("trapezoidal_servo_profile: mismatch");
		$finish;
	end

endmodule
